@@ rtl/sgaf_pkg.sv @@
// Shared types and constants for the stick gesture arming block.
`timescale 1ns / 1ps
`default_nettype none

package sgaf_pkg;

	localparam int unsigned LevelW = 11;
	localparam int unsigned HoldW  = 16;
	localparam int unsigned ModeW  = 2;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;

	// Reset values of the configuration registers.
	localparam logic [HoldW-1:0]  HOLD_TICKS_RST     = 16'd50;
	localparam logic [LevelW-1:0] LOW_THRESHOLD_RST  = 11'd400;
	localparam logic [LevelW-1:0] HIGH_THRESHOLD_RST = 11'd1500;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_HOLD_TICKS     = 2'd0,
		CFG_LOW_THRESHOLD  = 2'd1,
		CFG_HIGH_THRESHOLD = 2'd2,
		CFG_UNUSED         = 2'd3
	} cfg_idx_t;

	// Encoding of the arm_mode result field.
	typedef enum logic [ModeW-1:0] {
		ARM_LOCKED   = 2'd0,
		ARM_UNLOCKED = 2'd1,
		ARM_CALIB    = 2'd2,
		ARM_LOST     = 2'd3
	} arm_code_t;

	// Gesture seen on one tick, already resolved by priority.
	typedef enum logic [2:0] {
		GEST_NONE   = 3'd0,
		GEST_LOCK   = 3'd1,
		GEST_UNLOCK = 3'd2,
		GEST_CALIB  = 3'd3,
		GEST_LOST   = 3'd4
	} gest_t;

	typedef struct packed {
		logic [HoldW-1:0]  hold_ticks;
		logic [LevelW-1:0] low_threshold;
		logic [LevelW-1:0] high_threshold;
	} cfg_t;

	typedef struct packed {
		logic [LevelW-1:0] throttle_level;
		logic [LevelW-1:0] yaw_level;
		logic [LevelW-1:0] pitch_level;
		logic [LevelW-1:0] roll_level;
	} levels_t;

	typedef struct packed {
		logic [ModeW-1:0] arm_mode;
		logic             neutral_flag;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/sgaf_if.sv @@
// Valid/ready channel interfaces for stick levels in and arming status out.
`timescale 1ns / 1ps
`default_nettype none

interface sgaf_stick_if;
	logic                          valid;
	logic                          ready;
	logic [sgaf_pkg::LevelW-1:0]   throttle_level;
	logic [sgaf_pkg::LevelW-1:0]   yaw_level;
	logic [sgaf_pkg::LevelW-1:0]   pitch_level;
	logic [sgaf_pkg::LevelW-1:0]   roll_level;

	modport source (output valid, throttle_level, yaw_level, pitch_level, roll_level,
		input ready);
	modport sink (input valid, throttle_level, yaw_level, pitch_level, roll_level,
		output ready);
endinterface

interface sgaf_arm_if;
	logic                          valid;
	logic                          ready;
	logic [sgaf_pkg::ModeW-1:0]    arm_mode;
	logic                          neutral_flag;

	modport source (output valid, arm_mode, neutral_flag, input ready);
	modport sink (input valid, arm_mode, neutral_flag, output ready);
endinterface

`default_nettype wire

@@ rtl/sgaf_cfg_regs.sv @@
// Configuration register file: hold time and the two stick thresholds.
`timescale 1ns / 1ps
`default_nettype none

module sgaf_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sgaf_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [sgaf_pkg::CfgDataW-1:0]   cfg_data,
	output sgaf_pkg::cfg_t                       cfg
);

	sgaf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks     <= sgaf_pkg::HOLD_TICKS_RST;
			cfg_q.low_threshold  <= sgaf_pkg::LOW_THRESHOLD_RST;
			cfg_q.high_threshold <= sgaf_pkg::HIGH_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (sgaf_pkg::cfg_idx_t'(cfg_index))
				sgaf_pkg::CFG_HOLD_TICKS: begin
					cfg_q.hold_ticks <= cfg_data[sgaf_pkg::HoldW-1:0];
				end
				sgaf_pkg::CFG_LOW_THRESHOLD: begin
					cfg_q.low_threshold <= cfg_data[sgaf_pkg::LevelW-1:0];
				end
				sgaf_pkg::CFG_HIGH_THRESHOLD: begin
					cfg_q.high_threshold <= cfg_data[sgaf_pkg::LevelW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/sgaf_gesture_dec.sv @@
// Threshold compares and priority decode of the four stick gestures.
`timescale 1ns / 1ps
`default_nettype none

module sgaf_gesture_dec (
	input  wire sgaf_pkg::levels_t levels,
	input  wire sgaf_pkg::cfg_t    cfg,
	output sgaf_pkg::gest_t        gest
);

	logic thr_lo, yaw_lo, yaw_hi, pit_lo, pit_hi, rol_lo, rol_hi;

	// A level may be low and high at once when the thresholds overlap.
	assign thr_lo = levels.throttle_level <= cfg.low_threshold;
	assign yaw_lo = levels.yaw_level      <= cfg.low_threshold;
	assign yaw_hi = levels.yaw_level      >= cfg.high_threshold;
	assign pit_lo = levels.pitch_level    <= cfg.low_threshold;
	assign pit_hi = levels.pitch_level    >= cfg.high_threshold;
	assign rol_lo = levels.roll_level     <= cfg.low_threshold;
	assign rol_hi = levels.roll_level     >= cfg.high_threshold;

	always_comb begin
		if (thr_lo && yaw_hi && pit_hi && rol_lo) begin
			gest = sgaf_pkg::GEST_LOCK;
		end else if (thr_lo && yaw_lo && pit_hi && rol_hi) begin
			gest = sgaf_pkg::GEST_UNLOCK;
		end else if (thr_lo && yaw_lo && pit_lo && rol_hi) begin
			gest = sgaf_pkg::GEST_CALIB;
		end else if (thr_lo && yaw_lo && pit_hi && rol_lo) begin
			gest = sgaf_pkg::GEST_LOST;
		end else begin
			gest = sgaf_pkg::GEST_NONE;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sgaf_arm_ctrl.sv @@
// Arming state machine with the three gesture hold counters.
`timescale 1ns / 1ps
`default_nettype none

module sgaf_arm_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire sgaf_pkg::gest_t              gest,
	input  wire logic [sgaf_pkg::HoldW-1:0]   hold_ticks,
	output sgaf_pkg::result_t                 result
);

	typedef enum logic [3:0] {
		ST_LOCKED   = 4'b0001,
		ST_UNLOCKED = 4'b0010,
		ST_CALIB    = 4'b0100,
		ST_LOST     = 4'b1000
	} mode_t;

	mode_t                      mode_q, mode_d;
	logic                       neutral_q, neutral_d;
	logic [sgaf_pkg::HoldW-1:0] lock_run_q, unlock_run_q, calib_run_q;
	logic [sgaf_pkg::HoldW-1:0] lock_run_d, unlock_run_d, calib_run_d;
	logic [sgaf_pkg::HoldW-1:0] lock_inc, unlock_inc, calib_inc;
	logic                       plain_calib, plain_lock;
	logic                       wr_mode;
	mode_t                      wr_val;

	assign plain_calib = (mode_q == ST_CALIB) && !neutral_q;
	assign plain_lock  = (mode_q == ST_LOCKED) && !neutral_q;
	assign lock_inc    = lock_run_q + 1'b1;
	assign unlock_inc  = unlock_run_q + 1'b1;
	assign calib_inc   = calib_run_q + 1'b1;

	always_comb begin
		lock_run_d   = '0;
		unlock_run_d = '0;
		calib_run_d  = '0;
		neutral_d    = neutral_q;
		wr_mode      = 1'b0;
		wr_val       = mode_q;
		unique case (gest)
			sgaf_pkg::GEST_LOCK: begin
				if (lock_inc == hold_ticks) begin
					wr_mode = 1'b1;
					wr_val  = ST_LOCKED;
				end else begin
					lock_run_d = lock_inc;
				end
			end
			sgaf_pkg::GEST_UNLOCK: begin
				if (unlock_inc == hold_ticks) begin
					wr_mode = !plain_calib;
					wr_val  = ST_UNLOCKED;
				end else begin
					unlock_run_d = unlock_inc;
				end
			end
			sgaf_pkg::GEST_CALIB: begin
				if (calib_inc == hold_ticks) begin
					wr_mode = plain_lock;
					wr_val  = ST_CALIB;
				end else begin
					calib_run_d = calib_inc;
				end
			end
			sgaf_pkg::GEST_LOST: begin
				wr_mode = !plain_calib;
				wr_val  = ST_LOST;
			end
			default: begin
				neutral_d = 1'b1;
			end
		endcase
		// Any write of the mode clears the flag, even one that keeps the mode.
		mode_d = mode_q;
		if (wr_mode) begin
			mode_d    = wr_val;
			neutral_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ST_LOCKED;
			neutral_q    <= 1'b0;
			lock_run_q   <= '0;
			unlock_run_q <= '0;
			calib_run_q  <= '0;
		end else if (step) begin
			mode_q       <= mode_d;
			neutral_q    <= neutral_d;
			lock_run_q   <= lock_run_d;
			unlock_run_q <= unlock_run_d;
			calib_run_q  <= calib_run_d;
		end
	end

	always_comb begin
		unique case (mode_d)
			ST_LOCKED:   result.arm_mode = sgaf_pkg::ARM_LOCKED;
			ST_UNLOCKED: result.arm_mode = sgaf_pkg::ARM_UNLOCKED;
			ST_CALIB:    result.arm_mode = sgaf_pkg::ARM_CALIB;
			ST_LOST:     result.arm_mode = sgaf_pkg::ARM_LOST;
			default:     result.arm_mode = sgaf_pkg::ARM_LOCKED;
		endcase
		result.neutral_flag = neutral_d;
	end

	// Only one gesture can be counting at a time.
	a_one_counter: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({lock_run_q != '0, unlock_run_q != '0, calib_run_q != '0}) <= 1)
		else $error("more than one hold counter is running");

	// A tick with no gesture leaves every counter clear and the flag set.
	a_neutral_tick: assert property (@(posedge clk) disable iff (!arst_n)
		step && gest == sgaf_pkg::GEST_NONE |=>
		neutral_q && lock_run_q == '0 && unlock_run_q == '0 && calib_run_q == '0)
		else $error("neutral tick did not clear the counters");

	// The state only moves on an accepted tick.
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(mode_q) && $stable(neutral_q))
		else $error("arming state changed without a tick");

	// A mode change always comes with a cleared flag.
	a_change_clears: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != $past(mode_q) |-> !neutral_q)
		else $error("mode changed but neutral flag stayed set");

	// Calibration is entered only from plain lock.
	a_calib_entry: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_q != ST_CALIB && !plain_lock |=> mode_q != ST_CALIB)
		else $error("calibration entered from a mode other than plain lock");

endmodule

`default_nettype wire

@@ rtl/stick_gesture_arming_fsm_core.sv @@
// Top level of the stick gesture arming block: input stage, decode, state, result stage.
`timescale 1ns / 1ps
`default_nettype none

// Stick gesture arming core. Each beat on the stick channel is one control tick carrying the
// throttle, yaw, pitch and roll levels; each tick yields exactly one beat on the arming channel
// with the mode (0 locked, 1 unlocked, 2 calibrating, 3 link lost) and the neutral flag as they
// stand after that tick. A tick is captured in an input register, and when the result register is
// free or being emptied, the threshold compares, gesture priority decode and state update run in
// one short combinational pass that writes the result register, so the block sustains one tick per
// clock while the arming channel does not stall. A result is offered on the arming channel once it
// has been written into the result register. The result register decouples the sides: the
// block keeps taking ticks while a result waits, and only stops when both the input register
// and the result register are full and the arming channel is stalled. Lock, unlock and
// calibrate gestures act after hold_ticks consecutive ticks (a count of zero means 65536 ticks);
// the lost gesture acts at once. Configuration is written through cfg_we, cfg_index and
// cfg_data (index 0 hold_ticks, 1 low_threshold, 2 high_threshold; index 3 is ignored) and
// should only be written while no tick is in flight.
module stick_gesture_arming_fsm_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	sgaf_stick_if.sink                           sticks,
	sgaf_arm_if.source                           arming,
	input  wire logic                            cfg_we,
	input  wire logic [sgaf_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [sgaf_pkg::CfgDataW-1:0]   cfg_data
);

	sgaf_pkg::cfg_t    cfg;
	sgaf_pkg::levels_t levels_s1;
	logic              valid_s1;
	sgaf_pkg::gest_t   gest;
	sgaf_pkg::result_t result_nxt;
	sgaf_pkg::result_t result_s2;
	logic              valid_s2;
	logic              step;
	logic              take_in;

	sgaf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The held tick moves into the result register whenever that register is free
	// or is being emptied in this same cycle.
	assign step    = valid_s1 && (!valid_s2 || arming.ready);
	assign take_in = sticks.valid && sticks.ready;
	assign sticks.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sticks.ready) begin
			valid_s1 <= sticks.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			levels_s1.throttle_level <= sticks.throttle_level;
			levels_s1.yaw_level      <= sticks.yaw_level;
			levels_s1.pitch_level    <= sticks.pitch_level;
			levels_s1.roll_level     <= sticks.roll_level;
		end
	end

	sgaf_gesture_dec u_dec (
		.levels (levels_s1),
		.cfg    (cfg),
		.gest   (gest)
	);

	sgaf_arm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.gest       (gest),
		.hold_ticks (cfg.hold_ticks),
		.result     (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (arming.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result_nxt;
		end
	end

	assign arming.valid        = valid_s2;
	assign arming.arm_mode     = result_s2.arm_mode;
	assign arming.neutral_flag = result_s2.neutral_flag;

	// Every tick in the input register is either moved on or still held.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1)
		else $error("held tick lost before reaching the result register");

	// An unaccepted result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !valid_s2 || arming.ready)
		else $error("result register overwritten while still pending");

	// A tick taken while the input register is full must be the one leaving it.
	a_take_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		take_in && valid_s1 |-> step)
		else $error("tick accepted into a full input register");

endmodule

`default_nettype wire
